// ===== hdl/zbp_pkg.sv =====
package zbp_pkg;

  // Opcodes and prefixes that the predecoder recognizes.
  localparam logic [7:0] OpCall     = 8'hCD;
  localparam logic [7:0] OpJp       = 8'hC3;
  localparam logic [7:0] PrefixEd   = 8'hED;
  localparam logic [7:0] PrefixDd   = 8'hDD;
  localparam logic [7:0] PrefixFd   = 8'hFD;
  localparam logic [7:0] OpDjnz     = 8'h10;
  localparam logic [7:0] OpJr       = 8'h18;
  localparam logic [7:0] OpJrNz     = 8'h20;
  localparam logic [7:0] OpJrZ      = 8'h28;
  localparam logic [7:0] OpJrNc     = 8'h30;
  localparam logic [7:0] OpJrC      = 8'h38;
  localparam logic [7:0] OpJpHl     = 8'hE9;
  localparam logic [7:0] OpRet      = 8'hC9;
  localparam logic [7:0] OpRetZ     = 8'hC8;
  localparam logic [7:0] OpRetC     = 8'hD8;
  localparam logic [7:0] OpRetPe    = 8'hE8;
  localparam logic [7:0] OpRetM     = 8'hF8;
  localparam logic [7:0] OpLdNnHl   = 8'h22;
  localparam logic [7:0] OpLdNnA    = 8'h32;
  localparam logic [7:0] OpLdHlNn   = 8'h2A;
  localparam logic [7:0] OpLdANn    = 8'h3A;
  localparam logic [7:0] OpLdBcImm  = 8'h01;
  localparam logic [7:0] OpLdDeImm  = 8'h11;
  localparam logic [7:0] OpLdHlImm  = 8'h21;

  // Opcode group masks and patterns.
  localparam logic [7:0] GroupMask    = 8'hC7;
  localparam logic [7:0] GroupRst     = 8'hC7;
  localparam logic [7:0] GroupCallCc  = 8'hC4;
  localparam logic [7:0] GroupJpCc    = 8'hC2;
  localparam logic [7:0] GroupEdRet   = 8'h45;
  localparam logic [7:0] GroupEdLdMem = 8'h43;
  localparam logic [7:0] RstVecMask   = 8'h38;

  // One request: program counter and the first four instruction bytes.
  typedef struct packed {
    logic [15:0] pc;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [7:0]  byte3;
  } req_t;

  // One predecode result.
  typedef struct packed {
    logic        is_jump;
    logic [15:0] jump_target;
    logic        is_call;
    logic        is_stop;
    logic        has_pointer_ref;
    logic [15:0] pointer_ref_addr;
    logic        has_indirection;
    logic [15:0] indirection_addr;
  } rsp_t;

endpackage

// ===== hdl/z80_branch_pointer_predecode.sv =====
// Z80 branch and pointer predecoder.
// A request taken with start passes through the input register, then decode logic
// into the result register, whose valid bit drives the result strobe done_o.
// Throughput: one request per cycle; busy is always low and the receiver cannot stall.
// Reset clears the valid pipeline and sets the CPU-type register to Z80.
module z80_branch_pointer_predecode (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  zbp_pkg::req_t    req_i,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  output logic             done_o,
  output zbp_pkg::rsp_t    rsp_o
);

  logic          cpu_is_z80_q;
  logic          in_valid_q;
  zbp_pkg::req_t in_q;
  logic          out_valid_q;
  zbp_pkg::rsp_t rsp_d;
  zbp_pkg::rsp_t rsp_q;

  // The pipeline never holds a request off.
  assign busy = 1'b0;

  // CPU-type configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_is_z80_q <= 1'b1;
    end else if (cfg_we_i) begin
      cpu_is_z80_q <= cfg_wdata_i;
    end
  end

  // Input register stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      in_q <= req_i;
    end
  end

  // Decode of the registered request.
  always_comb begin
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [15:0] w12;
    logic [15:0] w23;
    logic        idx;
    logic        is_rst;
    logic        call;
    logic        jp;
    logic        rel;
    logic        ind;
    logic [15:0] ind_addr;

    b0     = in_q.byte0;
    b1     = in_q.byte1;
    w12    = {in_q.byte2, in_q.byte1};
    w23    = {in_q.byte3, in_q.byte2};
    idx    = (b0 == zbp_pkg::PrefixDd) || (b0 == zbp_pkg::PrefixFd);
    is_rst = (b0 & zbp_pkg::GroupMask) == zbp_pkg::GroupRst;
    call   = (b0 == zbp_pkg::OpCall) || is_rst ||
             ((b0 & zbp_pkg::GroupMask) == zbp_pkg::GroupCallCc);
    jp     = (b0 == zbp_pkg::OpJp) || ((b0 & zbp_pkg::GroupMask) == zbp_pkg::GroupJpCc);
    rel    = (b0 == zbp_pkg::OpDjnz) || (b0 == zbp_pkg::OpJr) ||
             (b0 == zbp_pkg::OpJrNz) || (b0 == zbp_pkg::OpJrZ) ||
             (b0 == zbp_pkg::OpJrNc) || (b0 == zbp_pkg::OpJrC);

    rsp_d = '0;

    // Branch target: RST vector, absolute operand or relative displacement.
    priority if (is_rst) begin
      rsp_d.is_jump     = 1'b1;
      rsp_d.jump_target = {8'h00, b0 & zbp_pkg::RstVecMask};
    end else if (call || jp) begin
      rsp_d.is_jump     = 1'b1;
      rsp_d.jump_target = w12;
    end else if (rel) begin
      rsp_d.is_jump     = 1'b1;
      rsp_d.jump_target = in_q.pc + 16'd2 + {{8{b1[7]}}, b1};
    end else begin
      rsp_d.is_jump     = 1'b0;
    end

    rsp_d.is_call = call;

    // Instructions that end linear tracing.
    rsp_d.is_stop = call || (b0 == zbp_pkg::OpRetZ) || (b0 == zbp_pkg::OpRet) ||
                    (b0 == zbp_pkg::OpRetC) || (b0 == zbp_pkg::OpRetPe) ||
                    (b0 == zbp_pkg::OpRetM) || (b0 == zbp_pkg::OpJp) ||
                    (b0 == zbp_pkg::OpJpHl) || (b0 == zbp_pkg::OpJr) ||
                    ((b0 == zbp_pkg::PrefixEd) &&
                     ((b1 & zbp_pkg::GroupMask) == zbp_pkg::GroupEdRet)) ||
                    (idx && (b1 == zbp_pkg::OpJpHl));

    // Loads and stores through an absolute address.
    ind      = 1'b0;
    ind_addr = '0;
    priority if ((b0 == zbp_pkg::OpLdNnHl) || (b0 == zbp_pkg::OpLdNnA) ||
                 (b0 == zbp_pkg::OpLdHlNn) || (b0 == zbp_pkg::OpLdANn)) begin
      ind      = 1'b1;
      ind_addr = w12;
    end else if ((b0 == zbp_pkg::PrefixEd) &&
                 ((b1 & zbp_pkg::GroupMask) == zbp_pkg::GroupEdLdMem)) begin
      ind      = 1'b1;
      ind_addr = w23;
    end else if (idx && ((b1 == zbp_pkg::OpLdNnHl) || (b1 == zbp_pkg::OpLdHlNn))) begin
      ind      = 1'b1;
      ind_addr = w23;
    end else begin
      ind      = 1'b0;
    end
    rsp_d.has_indirection  = ind;
    rsp_d.indirection_addr = ind_addr;

    // Pointer reference: indirect address first, then 16-bit immediates.
    priority if (ind) begin
      rsp_d.has_pointer_ref  = 1'b1;
      rsp_d.pointer_ref_addr = ind_addr;
    end else if ((b0 == zbp_pkg::OpLdBcImm) || (b0 == zbp_pkg::OpLdDeImm) ||
                 (b0 == zbp_pkg::OpLdHlImm)) begin
      rsp_d.has_pointer_ref  = 1'b1;
      rsp_d.pointer_ref_addr = w12;
    end else if (idx && (b1 == zbp_pkg::OpLdHlImm)) begin
      rsp_d.has_pointer_ref  = 1'b1;
      rsp_d.pointer_ref_addr = w23;
    end else begin
      rsp_d.has_pointer_ref  = 1'b0;
    end

    // Another CPU type reports nothing.
    if (!cpu_is_z80_q) begin
      rsp_d = '0;
    end
  end

  // Result register stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = out_valid_q;
  assign rsp_o  = rsp_q;

`ifndef NO_ASSERTIONS
  // Every accepted request gives a result strobe after the input and result registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##2 done_o)
    else $error("accepted request produced no result");

  // A result without the jump flag carries a zero target.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !rsp_o.is_jump |-> rsp_o.jump_target == 16'h0000)
    else $error("jump target set without jump");

  // An indirect access is also the pointer reference, with the same address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.has_indirection |->
      rsp_o.has_pointer_ref && (rsp_o.pointer_ref_addr == rsp_o.indirection_addr))
    else $error("indirection not reported as pointer reference");

  // Calls always branch and end tracing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.is_call |-> rsp_o.is_jump && rsp_o.is_stop)
    else $error("call without jump or stop");
`endif

endmodule
